>>> design/matrix3x3_inverse_top_defines.svh
// Assertion macros for the 3x3 inverse block
`ifndef MATRIX3X3_INVERSE_TOP_DEFINES_SVH
`define MATRIX3X3_INVERSE_TOP_DEFINES_SVH
// assert that an antecedent implies a consequent on the next edge
`define M3I_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
// assert that a condition holds at every edge
`define M3I_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`endif

>>> design/m3i_pkg.sv
//------------------------------------------------------------------------------
// m3i_pkg
// Types and constants shared by the 3x3 inverse pipeline.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package m3i_pkg;
	localparam int unsigned ElemW = 16;
	localparam int unsigned CofW  = 33;
	localparam int unsigned DetW  = 50;
	localparam int unsigned NumW  = 61;
	localparam int unsigned QuoW  = 62;
	localparam int unsigned OutW  = 32;
	localparam int unsigned QShift = 28;
	localparam int unsigned NLanes = 9;

	typedef struct packed {
		logic signed [ElemW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
	} m3i_in_t;

	typedef struct packed {
		logic signed [OutW-1:0] inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
		logic invertible;
	} m3i_out_t;
endpackage

>>> design/matrix3x3_inverse_top.sv
//------------------------------------------------------------------------------
// matrix3x3_inverse_top
// 3x3 matrix inverse by adjugate over determinant, fully pipelined.
//------------------------------------------------------------------------------
// Usage:
//  in channel  (in_valid/in_ready/in_data):  one matrix item, nine Q4.12 entries.
//  out channel (out_valid/out_ready/out_data): nine Q16.16 elements plus the
//  invertible flag; a singular matrix gives all zeros and invertible low.
//  Throughput: one item per cycle while the receiver does not stall. Pipeline:
//  cofactor and determinant stages, a divider input register and 62 divider
//  stages, and one output register.
//  Most of the pipeline depth lies in the nine divider lanes, each a 62-stage
//  restoring divider producing one quotient bit per stage.
//  The whole pipeline advances only when the output register is free or being
//  taken, so a stalled receiver holds every item in place; in_ready follows.
//  Reset clears the valid bits of all stages; payload is not reset.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "matrix3x3_inverse_top_defines.svh"
module matrix3x3_inverse_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  m3i_pkg::m3i_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output m3i_pkg::m3i_out_t out_data
);
	import m3i_pkg::*;
	// cofactor/determinant stages, divider input register plus stages, output register
	localparam int unsigned Lat = 3 + (QuoW + 1) + 1;

	logic en;
	logic [Lat-1:0] vld_q;
	logic signed [CofW-1:0] adj [9];
	logic signed [DetW-1:0] det;
	logic signed [OutW-1:0] quo [9];
	logic nz_q [QuoW+1];

	// stall everything when the final stage holds an untaken item
	assign en = !vld_q[Lat-1] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[Lat-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[Lat-2:0], in_valid};
	end

	m3i_cof u_cof (.clk, .en, .m(in_data), .adj, .det);

	// nine lanes, one per inverse element
	for (genvar l = 0; l < NLanes; l++) begin : g_lane
		m3i_div_lane u_div (.clk, .en, .cof(adj[l]), .det, .quo(quo[l]));
	end

	// singular flag travels beside the lanes
	always_ff @(posedge clk) begin
		if (en) begin
			nz_q[0] <= (det != '0);
			for (int s = 0; s < QuoW; s++)
				nz_q[s+1] <= nz_q[s];
		end
	end

	// merging stage: output register
	always_ff @(posedge clk) begin
		if (en) begin
			if (nz_q[QuoW]) begin
				out_data <= {quo[0], quo[1], quo[2], quo[3], quo[4], quo[5],
					quo[6], quo[7], quo[8], 1'b1};
			end else begin
				out_data <= '0;
			end
		end
	end

	`M3I_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "held item changed")
	`M3I_ASSERT_ALWAYS(a_ready, clk, arst_n, in_ready == (!out_valid || out_ready), "ready mismatch")
	`M3I_ASSERT_ALWAYS(a_sing, clk, arst_n, !out_valid || out_data.invertible || out_data.inv00 == '0, "singular output nonzero")
endmodule

>>> design/m3i_div_lane.sv
//------------------------------------------------------------------------------
// m3i_div_lane
// Pipelined restoring divider: one quotient bit per stage, then saturation.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module m3i_div_lane (
	input  logic                            clk,
	input  logic                            en,
	input  logic signed [m3i_pkg::CofW-1:0] cof,
	input  logic signed [m3i_pkg::DetW-1:0] det,
	output logic signed [m3i_pkg::OutW-1:0] quo
);
	import m3i_pkg::*;
	localparam int unsigned NS = QuoW;

	logic [NumW-1:0] num_mag;
	logic [DetW-1:0] den_mag;
	logic            neg;
	logic [NumW-1:0] n_q   [NS+1];
	logic [QuoW-1:0] q_q   [NS+1];
	logic [DetW:0]   r_q   [NS+1];
	logic [DetW-1:0] d_q   [NS+1];
	logic            neg_q [NS+1];
	logic [QuoW-1:0] qf;
	logic signed [QuoW:0] qs;

	always_comb begin
		logic signed [NumW-1:0] ns;
		ns = NumW'(cof) <<< QShift;
		num_mag = ns[NumW-1] ? NumW'(-ns) : ns;
		den_mag = det[DetW-1] ? DetW'(-det) : DetW'(det);
		neg = cof[CofW-1] ^ det[DetW-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_q[0] <= num_mag;
			d_q[0] <= den_mag;
			q_q[0] <= '0;
			r_q[0] <= '0;
			neg_q[0] <= neg;
		end
	end

	// one quotient bit per stage; numerator bits beyond NumW are zero
	for (genvar s = 0; s < NS; s++) begin : g_st
		logic [DetW+1:0] tr;
		logic [DetW+1:0] df;
		logic            nb;
		if (s >= NS - NumW) begin : g_nb
			assign nb = n_q[s][NS-1-s];
		end else begin : g_zb
			assign nb = 1'b0;
		end
		always_comb begin
			tr = {r_q[s], nb};
			df = tr - {2'b00, d_q[s]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				n_q[s+1] <= n_q[s];
				d_q[s+1] <= d_q[s];
				neg_q[s+1] <= neg_q[s];
				if (!df[DetW+1]) begin
					r_q[s+1] <= df[DetW:0];
					q_q[s+1] <= {q_q[s][QuoW-2:0], 1'b1};
				end else begin
					r_q[s+1] <= tr[DetW:0];
					q_q[s+1] <= {q_q[s][QuoW-2:0], 1'b0};
				end
			end
		end
	end

	always_comb begin
		qf = q_q[NS];
		qs = neg_q[NS] ? -$signed({1'b0, qf}) : $signed({1'b0, qf});
		if (qs > $signed((QuoW+1)'(32'h7fffffff)))
			quo = 32'sh7fffffff;
		else if (qs < -$signed((QuoW+1)'(33'h080000000)))
			quo = 32'sh80000000;
		else
			quo = qs[OutW-1:0];
	end
endmodule

>>> design/m3i_cof.sv
//------------------------------------------------------------------------------
// m3i_cof
// Cofactor and determinant stages: products registered, then sums.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module m3i_cof (
	input  logic                            clk,
	input  logic                            en,
	input  m3i_pkg::m3i_in_t                m,
	output logic signed [m3i_pkg::CofW-1:0] adj [9],
	output logic signed [m3i_pkg::DetW-1:0] det
);
	import m3i_pkg::*;
	logic signed [31:0] pp_s1 [18];
	m3i_in_t m_s1, m_s2;
	logic signed [CofW-1:0] c_s2 [9];
	logic signed [48:0] dp_s3 [3];
	logic signed [CofW-1:0] c_s3 [9];

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1 <= m;
			pp_s1[0] <= m.a11*m.a22; pp_s1[1] <= m.a12*m.a21;
			pp_s1[2] <= m.a02*m.a21; pp_s1[3] <= m.a01*m.a22;
			pp_s1[4] <= m.a01*m.a12; pp_s1[5] <= m.a02*m.a11;
			pp_s1[6] <= m.a12*m.a20; pp_s1[7] <= m.a10*m.a22;
			pp_s1[8] <= m.a00*m.a22; pp_s1[9] <= m.a02*m.a20;
			pp_s1[10] <= m.a02*m.a10; pp_s1[11] <= m.a00*m.a12;
			pp_s1[12] <= m.a10*m.a21; pp_s1[13] <= m.a11*m.a20;
			pp_s1[14] <= m.a20*m.a01; pp_s1[15] <= m.a00*m.a21;
			pp_s1[16] <= m.a00*m.a11; pp_s1[17] <= m.a01*m.a10;
			m_s2 <= m_s1;
			for (int i = 0; i < 9; i++)
				c_s2[i] <= CofW'(pp_s1[2*i]) - CofW'(pp_s1[2*i+1]);
			c_s3 <= c_s2;
			dp_s3[0] <= m_s2.a00 * c_s2[0];
			dp_s3[1] <= m_s2.a01 * c_s2[3];
			dp_s3[2] <= m_s2.a02 * c_s2[6];
		end
	end

	assign adj = c_s3;
	assign det = DetW'(dp_s3[0]) + DetW'(dp_s3[1]) + DetW'(dp_s3[2]);
endmodule

>>> tb/m3i_checker.sv
//------------------------------------------------------------------------------
// m3i_checker
// Watches both channels of the 3x3 inverse block, predicts every result from
// the accepted matrix and compares it field by field with what comes out.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module m3i_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  m3i_pkg::m3i_in_t  in_data,
	input  logic              out_valid,
	input  logic              out_ready,
	input  m3i_pkg::m3i_out_t out_data,
	output int                errors,
	output int                pending,
	output int                n_singular,
	output int                n_saturated
);
	import m3i_pkg::*;

	m3i_out_t inverse_q[$];

	function automatic logic signed [31:0] scale_div(longint num, longint den, ref int sat);
		logic signed [127:0] q;
		q = ($signed(128'(num)) <<< 28) / $signed(128'(den));
		if (q > 128'sd2147483647) begin
			sat++;
			return 32'sh7fffffff;
		end
		if (q < -128'sd2147483648) begin
			sat++;
			return 32'sh80000000;
		end
		return q[31:0];
	endfunction

	function automatic m3i_out_t invert_matrix(m3i_in_t m, ref int sing, ref int sat);
		longint e00, e01, e02, e10, e11, e12, e20, e21, e22, d;
		longint c[9];
		m3i_out_t r;
		e00 = m.a00; e01 = m.a01; e02 = m.a02;
		e10 = m.a10; e11 = m.a11; e12 = m.a12;
		e20 = m.a20; e21 = m.a21; e22 = m.a22;
		c[0] = e11*e22 - e12*e21;
		c[1] = e02*e21 - e01*e22;
		c[2] = e01*e12 - e02*e11;
		c[3] = e12*e20 - e10*e22;
		c[4] = e00*e22 - e02*e20;
		c[5] = e02*e10 - e00*e12;
		c[6] = e10*e21 - e11*e20;
		c[7] = e20*e01 - e00*e21;
		c[8] = e00*e11 - e01*e10;
		d = e00*c[0] + e01*c[3] + e02*c[6];
		r = '0;
		if (d == 0) begin
			sing++;
			return r;
		end
		r.inv00 = scale_div(c[0], d, sat);
		r.inv01 = scale_div(c[1], d, sat);
		r.inv02 = scale_div(c[2], d, sat);
		r.inv10 = scale_div(c[3], d, sat);
		r.inv11 = scale_div(c[4], d, sat);
		r.inv12 = scale_div(c[5], d, sat);
		r.inv20 = scale_div(c[6], d, sat);
		r.inv21 = scale_div(c[7], d, sat);
		r.inv22 = scale_div(c[8], d, sat);
		r.invertible = 1'b1;
		return r;
	endfunction

	task automatic cmp(string f, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			errors++;
			$display("%0t mismatch %s expected %h actual %h", $time, f, e, a);
		end
	endtask

	initial begin
		errors = 0; pending = 0; n_singular = 0; n_saturated = 0;
	end

	always @(posedge clk) begin
		m3i_out_t e;
		if (arst_n) begin
			if (in_valid && in_ready)
				inverse_q.push_back(invert_matrix(in_data, n_singular, n_saturated));
			if (out_valid && out_ready) begin
				if (inverse_q.size() == 0) begin
					errors++;
					$display("%0t unexpected result %h", $time, out_data);
				end else begin
					e = inverse_q.pop_front();
					cmp("inv00", e.inv00, out_data.inv00);
					cmp("inv01", e.inv01, out_data.inv01);
					cmp("inv02", e.inv02, out_data.inv02);
					cmp("inv10", e.inv10, out_data.inv10);
					cmp("inv11", e.inv11, out_data.inv11);
					cmp("inv12", e.inv12, out_data.inv12);
					cmp("inv20", e.inv20, out_data.inv20);
					cmp("inv21", e.inv21, out_data.inv21);
					cmp("inv22", e.inv22, out_data.inv22);
					cmp("invertible", 32'(e.invertible), 32'(out_data.invertible));
				end
			end
		end
		pending = inverse_q.size();
	end
endmodule

>>> tb/testbench.sv
//------------------------------------------------------------------------------
// testbench
// Drives matrices into the 3x3 inverse block with random gaps and receiver
// stalls; the checker predicts and compares, this module gives the verdict.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
	import m3i_pkg::*;

	localparam int LATENCY = 67;
	localparam int N_RANDOM = 600;
	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	m3i_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	m3i_out_t out_data;
	int errors, pending, n_singular, n_saturated;
	int cycles = 0;
	int n_items = 0;
	bit calm = 1'b0;	// stretches with no idling on either side

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	matrix3x3_inverse_top dut (.*);

	m3i_checker chk (.*);

	// Receiver: random stall length per item, driven at the falling edge.
	initial begin
		int w;
		forever begin
			@(negedge clk);
			w = calm ? 0 : $urandom_range(0, 6);
			if (w > 0) begin
				out_ready <= 1'b0;
				repeat (w) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// Timeout watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Drop valid for a random gap, then hold one item until accepted.
	task automatic send_matrix(m3i_in_t m);
		int g;
		g = calm ? 0 : $urandom_range(0, 6);
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= m;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		n_items++;
	endtask

	function automatic logic [15:0] rand_elem();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'(int'($urandom_range(0, 8191)) - 4096);	// near unity
			3: return 16'($urandom_range(0, 7)) - 16'd3;	// tiny values
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic m3i_in_t rand_matrix();
		m3i_in_t m;
		m = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
			rand_elem(), rand_elem(), rand_elem(), rand_elem()};
		// Occasionally copy a row so the matrix is singular.
		if ($urandom_range(0, 9) == 0) begin
			m.a20 = m.a00; m.a21 = m.a01; m.a22 = m.a02;
		end
		return m;
	endfunction

	initial begin
		m3i_in_t m;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: identity, zero, extremes, singular, tiny determinant.
		m = '0; m.a00 = 16'h1000; m.a11 = 16'h1000; m.a22 = 16'h1000;
		send_matrix(m);
		send_matrix('0);
		send_matrix({9{16'h7fff}});
		send_matrix({9{16'h8000}});
		m = '0; m.a00 = 16'h8000; m.a11 = 16'h8000; m.a22 = 16'h8000;
		send_matrix(m);
		m = '0; m.a00 = 16'h7fff; m.a11 = 16'h7fff; m.a22 = 16'h7fff;
		send_matrix(m);
		m = '0; m.a00 = 16'h0001; m.a11 = 16'h0001; m.a22 = 16'h0001;
		send_matrix(m);	// huge inverse, still inside the Q16.16 range
		m = '0; m.a00 = 16'hffff; m.a11 = 16'h0001; m.a22 = 16'h0001;
		send_matrix(m);	// huge negative first diagonal element
		m = '0; m.a01 = 16'h1000; m.a12 = 16'h1000; m.a20 = 16'h1000;
		send_matrix(m);	// permutation
		m = {16'h1000, 16'h2000, 16'h3000, 16'h4000, 16'h5000, 16'h6000,
			16'h7000, 16'h7fff, 16'h8000};
		send_matrix(m);
		m = {16'h1000, 16'h2000, 16'h3000, 16'h2000, 16'h4000, 16'h6000,
			16'h0001, 16'h0002, 16'h0003};
		send_matrix(m);	// two rows dependent
		m = {16'h8000, 16'h7fff, 16'h0000, 16'h7fff, 16'h8000, 16'h0000,
			16'h0000, 16'h0000, 16'h0001};
		send_matrix(m);
		m = {16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
			16'hffff, 16'h0001, 16'hf00f};
		send_matrix(m);

		// Pause until everything has drained.
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);

		// Random phase, with stretches of full rate.
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 100 == 0) calm = ($urandom_range(0, 2) == 0);
			send_matrix(rand_matrix());
		end
		in_valid <= 1'b0;
		calm = 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);

		$display("covered %0d matrices, %0d singular, %0d saturated elements",
			n_items, n_singular, n_saturated);
		if (errors == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
